/* sv/sdvc_pkg.sv */
// shared types, constants and state encoding for the sorted distinct value counter
// no dependencies

package sdvc_pkg;

    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_DUMP = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [COUNT_W-1:0]       out_count;
        logic                     entry_valid;
        logic                     overflowed;
        logic                     last;
    } t_out;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_DUMP_RD,
        S_DUMP_LD,
        S_DUMP_EMPTY
    } t_state;

endpackage

/* sv/sdvc_mem.sv */
// entry table memory: one write port, one read port with registered read data
// depends on nothing

module sdvc_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/sdvc_alu.sv */
// shared compare and saturating count unit
// depends on sdvc_pkg

module sdvc_alu #(
    parameter int VALUE_WIDTH = sdvc_pkg::DEF_VALUE_WIDTH
) (
    input  logic [VALUE_WIDTH-1:0]      i_entry,
    input  logic [VALUE_WIDTH-1:0]      i_key,
    input  logic [sdvc_pkg::COUNT_W-1:0] i_count,
    output sdvc_pkg::t_cmp              o_cmp,
    output logic [sdvc_pkg::COUNT_W-1:0] o_count_inc
);
    import sdvc_pkg::*;

    // signed order of two's complement values
    always_comb begin
        o_cmp.lt = $signed(i_entry) < $signed(i_key);
        o_cmp.eq = (i_entry == i_key);
    end

    // saturate at all ones
    assign o_count_inc = (&i_count) ? i_count : i_count + COUNT_W'(1);

endmodule

/* sv/sorted_distinct_value_counter.sv */
// top level of the sorted distinct value counter: sequencer, table memory, compare unit
// depends on sdvc_pkg, sdvc_mem, sdvc_alu

// The block counts occurrences of distinct signed values in a table held in
// ascending order in a single-port-read, single-port-write memory. An add item
// scans the table from the bottom, one entry per cycle, with one shared compare
// unit. A match bumps the count (saturating at all ones); otherwise the entries
// above the insertion point move up one place, each entry read in S_SHIFT_RD
// and written one place higher in S_SHIFT_WR, and the new value goes in with
// count 1. A new value that finds the table full is dropped and sets a sticky
// overflow flag. An add to an empty table goes straight to the insert. A dump
// item emits one result item per entry in ascending order, each entry read in
// S_DUMP_RD and loaded in S_DUMP_LD, which waits while the output register
// holds a result not yet taken; it marks the last one, then clears the table
// and the flag; a dump of an empty table gives one item with entry_valid low.
// Results sit in an output register, so a new input item can be accepted while
// the final result of a dump is still waiting to be taken. No item is accepted
// while an earlier one is still being worked on.

module sorted_distinct_value_counter #(
    parameter int MAX_ENTRIES = sdvc_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_WIDTH = sdvc_pkg::DEF_VALUE_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sdvc_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sdvc_pkg::t_out o_out
);
    import sdvc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = VALUE_WIDTH + COUNT_W;

    // control state
    t_state r_state, n_state;
    logic [CW-1:0] r_used, n_used;     // entries in the table
    logic          r_flag, n_flag;     // sticky overflow
    logic [CW-1:0] r_pos, n_pos;       // scan position, later insertion point
    logic [CW-1:0] r_idx, n_idx;       // shift and dump index
    logic          r_out_valid, n_out_valid;

    // payload
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    t_out                   r_out, n_out;

    // memory port
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [EW-1:0] w_rd_data;

    // entry fields from the read port
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic [COUNT_W-1:0]     w_rd_cnt;
    t_cmp                   w_cmp;
    logic [COUNT_W-1:0]     w_cnt_inc;

    // value width conversion on the way in and out
    logic [VALUE_WIDTH+DATA_W-1:0] w_in_ext;
    logic [VALUE_WIDTH+DATA_W-1:0] w_out_ext;

    logic w_in_acc;
    logic w_out_free;
    logic w_full;
    logic w_out_load;

    assign w_rd_val  = w_rd_data[EW-1:COUNT_W];
    assign w_rd_cnt  = w_rd_data[COUNT_W-1:0];
    assign w_in_ext  = {{VALUE_WIDTH{1'b0}}, i_in.value};
    assign w_out_ext = {{DATA_W{w_rd_val[VALUE_WIDTH-1]}}, w_rd_val};

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_used == CW'(MAX_ENTRIES));

    sdvc_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sdvc_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .i_entry     (w_rd_val),
        .i_key       (r_key),
        .i_count     (w_rd_cnt),
        .o_cmp       (w_cmp),
        .o_count_inc (w_cnt_inc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_flag      <= 1'b0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_flag      <= n_flag;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_flag     = r_flag;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_key      = r_key;
        n_out      = r_out;
        w_out_load = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_pos[AW-1:0];
        w_wr_data  = {r_key, COUNT_W'(1)};
        w_rd_addr  = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                w_rd_addr = '0;
                if (w_in_acc) begin
                    n_key = w_in_ext[VALUE_WIDTH-1:0];
                    n_pos = '0;
                    n_idx = '0;
                    if (i_in.action == ACT_DUMP) begin
                        n_state = (r_used == '0) ? S_DUMP_EMPTY : S_DUMP_RD;
                    end else begin
                        // empty table: straight to insert at the bottom
                        n_state = (r_used == '0) ? S_INSERT : S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                w_rd_addr = AW'(r_pos + CW'(1));
                if (w_cmp.eq) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {w_rd_val, w_cnt_inc};
                    n_state   = S_IDLE;
                end else if (w_cmp.lt) begin
                    if (r_pos + CW'(1) == r_used) begin
                        // larger than every entry: append
                        if (w_full) begin
                            n_flag  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_pos   = r_used;
                            n_state = S_INSERT;
                        end
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end else begin
                    // insert below the current entry, move the rest up
                    if (w_full) begin
                        n_flag  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_used;
                        n_state = S_SHIFT_RD;
                    end
                end
            end

            S_SHIFT_RD: begin
                w_rd_addr = AW'(r_idx - CW'(1));
                n_state   = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx[AW-1:0];
                w_wr_data = w_rd_data;
                n_idx     = r_idx - CW'(1);
                n_state   = (r_idx - CW'(1) == r_pos) ? S_INSERT : S_SHIFT_RD;
            end

            S_INSERT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos[AW-1:0];
                w_wr_data = {r_key, COUNT_W'(1)};
                n_used    = r_used + CW'(1);
                n_state   = S_IDLE;
            end

            S_DUMP_RD: begin
                n_state = S_DUMP_LD;
            end

            S_DUMP_LD: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    n_out.out_value   = w_out_ext[DATA_W-1:0];
                    n_out.out_count   = w_rd_cnt;
                    n_out.entry_valid = 1'b1;
                    n_out.overflowed  = r_flag;
                    n_out.last        = (r_idx + CW'(1) == r_used);
                    if (r_idx + CW'(1) == r_used) begin
                        n_used  = '0;
                        n_flag  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_DUMP_RD;
                    end
                end
            end

            S_DUMP_EMPTY: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    n_out.out_value   = '0;
                    n_out.out_count   = '0;
                    n_out.entry_valid = 1'b0;
                    n_out.overflowed  = r_flag;
                    n_out.last        = 1'b1;
                    n_flag            = 1'b0;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register: load takes priority over drain
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // table never holds more than its capacity
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // scan position stays inside the used part of the table
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_pos < r_used))
        else $error("scan beyond used entries");

    // shift never writes an entry at or below the insertion point
    a_shift_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> (r_idx > r_pos))
        else $error("shift below insertion point");

    // overflow only ever rises from a full table
    a_flag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_flag && n_flag) |-> w_full)
        else $error("overflow flagged on a table with room");

    // the final item of a dump leaves an empty table and a clear flag
    a_dump_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && n_out.last) |=> (r_used == '0 && !r_flag))
        else $error("table not cleared after dump");

endmodule

/* tb/sorted_distinct_value_counter_test.sv */
// self-checking testbench for the sorted distinct value counter: directed and random add/dump
// streams, with random idling on both handshakes; depends on sdvc_pkg and the block top level

`timescale 1ns / 1ps

module sorted_distinct_value_counter_test;
    import sdvc_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int CYCLE_LIMIT = 300000;
    // longest add is an insert at the bottom of a table with one free slot
    localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 50;
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    sorted_distinct_value_counter #(
        .MAX_ENTRIES(DEF_MAX_ENTRIES),
        .VALUE_WIDTH(DEF_VALUE_WIDTH)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in(in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out(out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // own copy of the table, always kept in ascending order
    logic signed [DATA_W-1:0] tally_values [TABLE_DEPTH];
    logic [COUNT_W-1:0]       tally_counts [TABLE_DEPTH];
    int                       tally_used = 0;
    logic                     tally_overflow = 1'b0;
    t_out                     dump_results [$];

    int  errors = 0;
    int  items_sent = 0;
    int  dumps_sent = 0;
    int  results_checked = 0;
    int  overflow_dumps = 0;
    int  cycle_count = 0;
    bit  calm_mode = 1'b0;
    int  out_hold = 0;

    // number of idle cycles before an item or after a result; none in calm stretches
    function automatic int pick_wait();
        if (calm_mode || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic void tally_add(input logic signed [DATA_W-1:0] v);
        int pos;
        pos = 0;
        while (pos < tally_used && tally_values[pos] < v)
            pos++;
        if (pos < tally_used && tally_values[pos] == v) begin
            if (tally_counts[pos] != '1)
                tally_counts[pos]++;
            return;
        end
        if (tally_used >= TABLE_DEPTH) begin
            tally_overflow = 1'b1;
            return;
        end
        for (int k = tally_used; k > pos; k--) begin
            tally_values[k] = tally_values[k-1];
            tally_counts[k] = tally_counts[k-1];
        end
        tally_values[pos] = v;
        tally_counts[pos] = 1;
        tally_used++;
    endfunction

    function automatic void tally_dump();
        t_out r;
        if (tally_overflow)
            overflow_dumps++;
        if (tally_used == 0) begin
            r = '0;
            r.overflowed = tally_overflow;
            r.last = 1'b1;
            dump_results.push_back(r);
        end else begin
            for (int k = 0; k < tally_used; k++) begin
                r.out_value = tally_values[k];
                r.out_count = tally_counts[k];
                r.entry_valid = 1'b1;
                r.overflowed = tally_overflow;
                r.last = (k == tally_used - 1);
                dump_results.push_back(r);
            end
        end
        tally_used = 0;
        tally_overflow = 1'b0;
    endfunction

    // called at an edge; returns at the edge where the item was taken
    task automatic send_item(input logic act, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{action: act, value: val};
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (act == ACT_DUMP) begin
            dumps_sent++;
            tally_dump();
        end else begin
            tally_add(val);
        end
    endtask

    function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // result side: check every taken item, then draw the stall before the next one
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (dump_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
            end else begin
                want = dump_results.pop_front();
                compare_field("out_value", want.out_value, out_item.out_value);
                compare_field("out_count", want.out_count, out_item.out_count);
                compare_field("entry_valid", want.entry_valid, out_item.entry_valid);
                compare_field("overflowed", want.overflowed, out_item.overflowed);
                compare_field("last", want.last, out_item.last);
            end
            out_hold = pick_wait();
        end else if (out_hold > 0) begin
            out_hold--;
        end
        out_ready <= (out_hold == 0);
    end

    task automatic test_empty_dump();
        send_item(ACT_DUMP, 32'h0);
        send_item(ACT_DUMP, VAL_MIN);
    endtask

    // extremes given out of order, with repeats; dump value field must be ignored
    task automatic test_sorted_order();
        send_item(ACT_ADD, 32'sd0);
        send_item(ACT_ADD, VAL_MAX);
        send_item(ACT_ADD, -32'sd1);
        send_item(ACT_ADD, VAL_MIN);
        send_item(ACT_ADD, 32'sd1);
        send_item(ACT_ADD, VAL_MAX);
        send_item(ACT_ADD, 32'sh5555_5555);
        send_item(ACT_ADD, 32'shAAAA_AAAA);
        send_item(ACT_ADD, -32'sd1);
        send_item(ACT_ADD, VAL_MIN);
        send_item(ACT_ADD, VAL_MIN);
        send_item(ACT_ADD, 32'sd0);
        send_item(ACT_DUMP, 32'hFFFF_FFFF);
    endtask

    task automatic test_single_entry();
        send_item(ACT_ADD, 32'sd5);
        send_item(ACT_DUMP, 32'sd5);
        send_item(ACT_DUMP, 32'h0);
    endtask

    // fill every slot, then a new value is dropped while known values still count
    task automatic test_table_overflow();
        bit seen [logic signed [DATA_W-1:0]];
        logic signed [DATA_W-1:0] v;
        int filled;
        seen[VAL_MIN] = 1'b1;
        seen[VAL_MAX] = 1'b1;
        send_item(ACT_ADD, VAL_MAX);
        send_item(ACT_ADD, VAL_MIN);
        filled = 2;
        while (filled < TABLE_DEPTH) begin
            v = $urandom;
            if (!seen.exists(v)) begin
                seen[v] = 1'b1;
                send_item(ACT_ADD, v);
                filled++;
            end
        end
        do
            v = $urandom;
        while (seen.exists(v));
        send_item(ACT_ADD, v);
        send_item(ACT_ADD, VAL_MIN);
        send_item(ACT_ADD, v);
        send_item(ACT_DUMP, v);
        send_item(ACT_DUMP, 32'h0);
    endtask

    // bursts of adds then a dump; value source varies from a tiny pool to the full range
    task automatic test_random_bursts(input int n_items);
        logic signed [DATA_W-1:0] pool [8];
        logic signed [DATA_W-1:0] v;
        int sent;
        int burst_len;
        int pool_size;
        int source;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(0, 14);
            pool_size = $urandom_range(1, 8);
            source = $urandom_range(0, 9);
            foreach (pool[i])
                pool[i] = $urandom;
            for (int j = 0; j < burst_len; j++) begin
                if (source < 6)
                    v = pool[$urandom_range(0, pool_size - 1)];
                else if (source < 8)
                    v = $urandom;
                else
                    v = $signed($urandom_range(0, 8)) - 4;
                send_item(ACT_ADD, v);
            end
            send_item(ACT_DUMP, $urandom);
            sent += burst_len + 1;
        end
    endtask

    task automatic test_back_to_back();
        calm_mode = 1'b1;
        test_random_bursts(25);
        calm_mode = 1'b0;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 dump_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_dump();
        test_sorted_order();
        test_single_entry();
        test_table_overflow();
        test_random_bursts(50);
        test_back_to_back();

        in_valid <= 1'b0;
        while (dump_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items including %0d dumps, checked %0d results", items_sent,
                 dumps_sent, results_checked);
        $display("%0d dumps reported a dropped value, %0d mismatches", overflow_dumps, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
